// ----- rtl/chte_pkg.sv -----
package chte_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 64;

  localparam int BUCKETS_DEF    = 16;
  localparam int POOL_NODES_DEF = 256;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } node_t;

endpackage

// ----- rtl/chte_req_if.sv -----
interface chte_req_if import chte_pkg::*; ();
  logic             valid;
  logic             ready;
  opcode_t          opcode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] record_value;

  modport source (output valid, opcode, key, record_value, input ready);
  modport sink   (input valid, opcode, key, record_value, output ready);
endinterface

// ----- rtl/chte_rsp_if.sv -----
interface chte_rsp_if import chte_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [VAL_W-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

// ----- rtl/chte_ram.sv -----
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/chte_hash.sv -----
module chte_hash import chte_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key_in,
  output logic             done,
  output logic [BW-1:0]    bucket
);

  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  if (IS_POW2) begin : g_mask
    localparam logic [KEY_W-1:0] KMASK = KEY_W'(BUCKETS - 1);
    logic          done_q;
    logic [BW-1:0] res;

    always_ff @(posedge clk) begin
      if (rst) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start;
      end
      if (start) begin
        res <= BW'(key_in & KMASK);
      end
    end

    assign done   = done_q;
    assign bucket = res;
  end else begin : g_recip
    // reciprocal multiply gives the quotient or one less, so the remainder
    // is below 2*BUCKETS: its low bits and one subtract finish it
    localparam int TW = BW + 1;
    localparam int MW = 2 * KEY_W;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);
    localparam logic [TW-1:0] DIV = TW'(BUCKETS);
    logic [MW-1:0] prod;
    logic [TW-1:0] q_lo;
    logic [TW-1:0] key_lo;
    logic [TW-1:0] rem_raw;
    logic [BW-1:0] rem;
    logic          mul_vld;
    logic          sub_vld;
    logic          done_q;

    assign prod = MW'(key_in) * MW'(RECIP);

    always_ff @(posedge clk) begin
      if (rst) begin
        mul_vld <= 1'b0;
        sub_vld <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        mul_vld <= start;
        sub_vld <= mul_vld;
        done_q  <= sub_vld;
      end
      if (start) begin
        q_lo   <= prod[KEY_W +: TW];
        key_lo <= key_in[TW-1:0];
      end
      if (mul_vld) begin
        rem_raw <= key_lo - q_lo * DIV;
      end
      if (sub_vld) begin
        rem <= (rem_raw >= DIV) ? BW'(rem_raw - DIV) : BW'(rem_raw);
      end
    end

    assign done   = done_q;
    assign bucket = rem;
  end

endmodule

// ----- rtl/chained_hash_table_engine_core.sv -----
// Chained hash table engine.
// Channel req (sink): opcode, key, record_value. Insert appends the record to
// the tail of chain (key mod BUCKETS); search returns the earliest inserted
// record with an equal key. Duplicate keys are kept. Nodes are never freed.
// Channel rsp (source): status and found_value, exactly one beat per req beat.
// One item is worked on at a time; req.ready is high only while idle.
// Bucket index: a registered mask for a power-of-two BUCKETS, else registered
// steps (reciprocal multiply, low-bit remainder, one correcting subtract).
// Insert: hash, bucket read, node write, tail link update (non-empty chain).
// Search: hash, bucket read, then a walk from the chain head, one node RAM read
// per cycle. A refused insert (pool full) skips the hash and the RAM reads.
// Reset: the bucket table is swept clear, entry by entry, with req.ready low.
// Stall: the result sits in the rsp output register; the next req beat is
// taken meanwhile and its work runs up to the point of loading a result.
module chained_hash_table_engine_core import chte_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  chte_req_if.sink   req,
  chte_rsp_if.source rsp
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW = $clog2(POOL_NODES);
  localparam int UW = $clog2(POOL_NODES + 1);
  localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } bkt_t;

  typedef struct packed {
    logic          has_next;
    logic [PW-1:0] next;
  } link_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_BRD    = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_NRD    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t           state;
  logic [BW-1:0]    bkt_cnt;
  opcode_t          op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [PW-1:0]    node_idx;
  logic [PW-1:0]    tail_q;
  logic [UW-1:0]    nodes_used;
  status_t          res_status;
  logic [VAL_W-1:0] res_value;
  logic             rsp_valid;
  status_t          rsp_status;
  logic [VAL_W-1:0] rsp_value;

  logic             accept;
  logic             full;
  logic             hash_start;
  logic             hash_done;
  logic [BW-1:0]    bucket;
  logic [PW-1:0]    n;

  logic             bkt_we;
  logic [BW-1:0]    bkt_waddr;
  bkt_t             bkt_wdata;
  bkt_t             bkt_rd;
  logic             dat_we;
  node_t            dat_rd;
  logic             lnk_we;
  logic [PW-1:0]    lnk_waddr;
  link_t            lnk_wdata;
  link_t            lnk_rd;
  logic [PW-1:0]    node_raddr;
  logic             is_ins;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign full            = (nodes_used == UW'(POOL_NODES));
  assign hash_start      = accept && !(req.opcode == OP_INSERT && full);
  assign n               = nodes_used[PW-1:0];
  assign is_ins          = (op_q == OP_INSERT);

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_value;

  chte_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key_in (req.key),
    .done   (hash_done),
    .bucket (bucket)
  );

  always_comb begin
    bkt_we    = (state == S_CLEAR) || (state == S_BRD && is_ins);
    bkt_waddr = (state == S_CLEAR) ? bkt_cnt : bucket;
    if (state == S_CLEAR) begin
      bkt_wdata = '0;
    end else begin
      bkt_wdata.valid = 1'b1;
      bkt_wdata.head  = bkt_rd.valid ? bkt_rd.head : n;
      bkt_wdata.tail  = n;
    end
    dat_we     = (state == S_BRD) && is_ins;
    lnk_we     = dat_we || (state == S_LINK);
    lnk_waddr  = (state == S_LINK) ? tail_q : n;
    if (state == S_LINK) begin
      lnk_wdata.has_next = 1'b1;
      lnk_wdata.next     = node_idx;
    end else begin
      lnk_wdata = '0;
    end
    node_raddr = (state == S_BRD) ? bkt_rd.head : lnk_rd.next;
  end

  chte_ram #(.WIDTH($bits(bkt_t)), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bucket),
    .rdata (bkt_rd)
  );

  chte_ram #(.WIDTH($bits(node_t)), .DEPTH(POOL_NODES)) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (n),
    .wdata ({key_q, val_q}),
    .raddr (node_raddr),
    .rdata (dat_rd)
  );

  chte_ram #(.WIDTH($bits(link_t)), .DEPTH(POOL_NODES)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (node_raddr),
    .rdata (lnk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      bkt_cnt    <= '0;
      nodes_used <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_FINISH && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          bkt_cnt <= bkt_cnt + 1'b1;
          if (bkt_cnt == BKT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.opcode;
            key_q <= req.key;
            val_q <= req.record_value;
            if (req.opcode == OP_INSERT && full) begin
              res_status <= ST_POOL_FULL;
              res_value  <= '0;
              state      <= S_FINISH;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          res_value <= '0;
          if (is_ins) begin
            node_idx   <= n;
            tail_q     <= bkt_rd.tail;
            nodes_used <= nodes_used + 1'b1;
            res_status <= ST_INSERTED;
            state      <= bkt_rd.valid ? S_LINK : S_FINISH;
          end else if (!bkt_rd.valid) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FINISH;
          end else begin
            state <= S_NRD;
          end
        end
        S_LINK: begin
          state <= S_FINISH;
        end
        S_NRD: begin
          if (dat_rd.key == key_q) begin
            res_status <= ST_FOUND;
            res_value  <= dat_rd.value;
            state      <= S_FINISH;
          end else if (!lnk_rd.has_next) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_status <= res_status;
            rsp_value  <= res_value;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/chained_hash_table_engine_core_test.sv -----
module chained_hash_table_engine_core_test;
  import chte_pkg::*;

  localparam int BUCKET_COUNT = BUCKETS_DEF;
  localparam int POOL_SIZE    = POOL_NODES_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] value;
  } reply_t;

  class chain_table_tracker;
    logic [KEY_W-1:0] node_key [POOL_SIZE];
    logic [VAL_W-1:0] node_value [POOL_SIZE];
    int unsigned      chain [BUCKET_COUNT][$];
    int unsigned      nodes_used;
    reply_t           pending_replies [$];
    int               mismatches;

    function new();
      nodes_used = 0;
      mismatches = 0;
    endfunction

    function void note_request(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      reply_t r;
      int     b;
      int     i;
      b = int'(key % BUCKET_COUNT);
      r.status = ST_NOT_FOUND;
      r.value = '0;
      if (op == OP_INSERT) begin
        if (nodes_used >= POOL_SIZE) begin
          r.status = ST_POOL_FULL;
        end else begin
          node_key[nodes_used] = key;
          node_value[nodes_used] = value;
          chain[b].push_back(nodes_used);
          nodes_used++;
          r.status = ST_INSERTED;
        end
      end else begin
        // earliest inserted match wins
        for (i = 0; i < chain[b].size() && r.status != ST_FOUND; i++) begin
          if (node_key[chain[b][i]] == key) begin
            r.status = ST_FOUND;
            r.value = node_value[chain[b][i]];
          end
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void check_response(status_t status, logic [VAL_W-1:0] value);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected response beat, status %0d value %h", $time, status, value);
        mismatches++;
      end else begin
        r = pending_replies.pop_front();
        if (status !== r.status) begin
          $display("%0t: status expected %0d got %0d", $time, r.status, status);
          mismatches++;
        end
        if (value !== r.value) begin
          $display("%0t: found_value expected %h got %h", $time, r.value, value);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  chte_req_if req_ch ();
  chte_rsp_if rsp_ch ();

  chained_hash_table_engine_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  chain_table_tracker tracker;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_left;
  int               cycle_count;
  logic [KEY_W-1:0] seen_keys [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        tracker.note_request(req_ch.opcode, req_ch.key, req_ch.record_value);
      if (rsp_ch.valid && rsp_ch.ready)
        tracker.check_response(rsp_ch.status, rsp_ch.found_value);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // response side: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct)
      gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key <= key;
    req_ch.record_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(bit for_search);
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 9);
    k = KEY_W'($urandom);
    if (seen_keys.size() > 0 && r < (for_search ? 6 : 3))
      k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    else if (r < 8)
      k[3:0] = 4'd3;  // pile into one bucket for long chains
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    return {$urandom, $urandom};
  endfunction

  initial begin
    opcode_t          op;
    logic [KEY_W-1:0] k;
    tracker = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.key = '0;
    req_ch.record_value = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send_item(OP_SEARCH, 31'd0, {VAL_W{1'b1}});
    send_item(OP_INSERT, 31'd0, '0);
    send_item(OP_INSERT, {KEY_W{1'b1}}, {VAL_W{1'b1}});
    send_item(OP_SEARCH, 31'd0, '0);
    send_item(OP_SEARCH, {KEY_W{1'b1}}, '0);
    send_item(OP_INSERT, 31'd16, 64'h0123_4567_89ab_cdef);
    send_item(OP_SEARCH, 31'd16, '0);
    send_item(OP_INSERT, 31'd0, 64'hdead_beef_cafe_f00d);
    send_item(OP_SEARCH, 31'd0, 64'h1);
    send_item(OP_SEARCH, 31'd32, '0);
    send_item(OP_INSERT, 31'h7fff_ffef, 64'h8000_0000_0000_0001);
    send_item(OP_SEARCH, {KEY_W{1'b1}}, '0);
    send_item(OP_SEARCH, 31'h7fff_ffef, '0);
    send_item(OP_SEARCH, 31'd5, '0);
    send_item(OP_INSERT, 31'h2aaa_aaaa, 64'h5555_5555_5555_5555);
    send_item(OP_INSERT, 31'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(OP_SEARCH, 31'h2aaa_aaaa, '0);
    send_item(OP_SEARCH, 31'h5555_5555, '0);
    send_item(OP_SEARCH, 31'h5555_5545, '0);

    // random, in idling phases; pool runs out part way through
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 130 == 0) begin
        case (i / 130)
          0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct = 56;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct = 56;
          end
          3: begin
            send_idle_pct = 7;
            recv_stall_pct = 7;
          end
          default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_left = 150;
          end
        endcase
      end
      op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_SEARCH;
      k = pick_key(op == OP_SEARCH);
      if (op == OP_INSERT)
        seen_keys.push_back(k);
      send_item(op, k, pick_value());
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
